// ----- hdl/acs_pkg.sv -----
// Package for the accumulator CPU step block: decoded item and result types,
// instruction field positions and the ALU helper functions.
// Used by acs_front, acs_back and accumulator_cpu_step_top; depends on nothing.
package acs_pkg;

  localparam int WORD_W = 16;
  localparam int BYTE_W = 8;

  // Both internal queues hold two entries; one pointer bit indexes them.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Instruction word fields.
  localparam int INS_COMPUTE = 0;
  localparam int INS_USE_MEM = 1;
  localparam int INS_OP_LO   = 2;
  localparam int INS_DST_LO  = 10;
  localparam int INS_JMP_LO  = 13;
  localparam int INS_LOAD_HI = 15;

  // ALU opcode flag bits.
  localparam int OP_F   = 0;  // add (1) or and (0); operand order for shifts
  localparam int OP_SH  = 1;  // shift instead of and/add
  localparam int OP_NY  = 2;
  localparam int OP_ZY  = 3;
  localparam int OP_NX  = 4;
  localparam int OP_ZX  = 5;
  localparam int OP_NO  = 6;
  localparam int OP_REV = 7;

  // Destination and jump condition bits.
  localparam int DST_MEM = 0;
  localparam int DST_D   = 1;
  localparam int DST_A   = 2;
  localparam int JMP_GT  = 0;
  localparam int JMP_EQ  = 1;
  localparam int JMP_LT  = 2;

  localparam logic [WORD_W-1:0] PC_STEP = 16'h0002;
  localparam logic [WORD_W-1:0] HALT_PC = 16'hFFFF;

  typedef logic [WORD_W-1:0] word_t;

  // One classified instruction as it leaves the front end.
  typedef struct packed {
    logic        is_compute;
    logic        use_mem;
    logic [7:0]  op;
    logic [2:0]  dst;
    logic [2:0]  jmp;
    word_t       load_value;
    word_t       mem_operand;
  } dec_t;

  typedef struct packed {
    word_t              next_pc;
    word_t              a_value;
    word_t              d_value;
    logic               mem_write;
    word_t              mem_write_addr;
    logic [BYTE_W-1:0]  mem_write_data;
    logic               halted;
  } res_t;

  // Shift by a signed amount: positive shifts left, negative shifts right
  // arithmetically; magnitudes of sixteen or more saturate.
  function automatic word_t shift_by(word_t value, word_t amount);
    word_t mag;
    word_t res;
    begin
      mag = word_t'(-amount);
      if (amount[WORD_W-1]) begin
        if (|mag[WORD_W-1:4]) begin
          res = {WORD_W{value[WORD_W-1]}};
        end else begin
          res = word_t'($signed(value) >>> mag[3:0]);
        end
      end else begin
        if (|amount[WORD_W-1:4]) begin
          res = '0;
        end else begin
          res = value << amount[3:0];
        end
      end
      return res;
    end
  endfunction

  function automatic word_t bit_reverse(word_t v);
    word_t r;
    begin
      for (int k = 0; k < WORD_W; k++) begin
        r[k] = v[WORD_W-1-k];
      end
      return r;
    end
  endfunction

endpackage

// ----- hdl/acs_front.sv -----
// Front end: accepts instruction beats, decodes them and holds them in a
// two-entry queue for the execute stage.
// Depends on acs_pkg.
module acs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [acs_pkg::WORD_W-1:0]   instruction,
  input  logic [acs_pkg::BYTE_W-1:0]   operand_byte,
  output logic                         dec_valid,
  output acs_pkg::dec_t                dec,
  input  logic                         dec_ready
);

  acs_pkg::dec_t                     q [acs_pkg::QUEUE_DEPTH];
  logic [acs_pkg::QPTR_W-1:0]        wr_ptr;
  logic [acs_pkg::QPTR_W-1:0]        rd_ptr;
  logic [acs_pkg::QCNT_W-1:0]        count;
  acs_pkg::dec_t                     dec_in;
  logic                              do_push;
  logic                              do_pop;

  always_comb begin
    dec_in.is_compute = instruction[acs_pkg::INS_COMPUTE];
    dec_in.use_mem    = instruction[acs_pkg::INS_USE_MEM];
    dec_in.op         = instruction[acs_pkg::INS_OP_LO +: 8];
    dec_in.dst        = instruction[acs_pkg::INS_DST_LO +: 3];
    dec_in.jmp        = instruction[acs_pkg::INS_JMP_LO +: 3];
    // Long loads keep the word with bit 0 forced high, short loads halve it.
    if (instruction[acs_pkg::INS_LOAD_HI]) begin
      dec_in.load_value = instruction | acs_pkg::word_t'(1);
    end else begin
      dec_in.load_value = instruction >> 1;
    end
    dec_in.mem_operand = {{(acs_pkg::WORD_W - acs_pkg::BYTE_W){operand_byte[acs_pkg::BYTE_W-1]}},
                          operand_byte};
  end

  assign full      = (count == acs_pkg::QCNT_W'(acs_pkg::QUEUE_DEPTH));
  assign dec_valid = (count != '0);
  assign dec       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = dec_valid && dec_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/acs_back.sv -----
// Back end: holds A, D, the program counter and the halt flag, executes one
// decoded instruction per cycle while its result queue has room, and queues
// the results in that two-entry queue. Depends on acs_pkg.
module acs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [acs_pkg::WORD_W-1:0]   cfg_data,
  input  logic                         dec_valid,
  input  acs_pkg::dec_t                dec,
  output logic                         dec_ready,
  output logic                         empty,
  input  logic                         pop,
  output acs_pkg::res_t                res
);

  acs_pkg::word_t                    prog_counter;
  acs_pkg::word_t                    reg_a;
  acs_pkg::word_t                    reg_d;
  logic                              halt_flag;
  acs_pkg::word_t                    prog_counter_next;
  acs_pkg::word_t                    reg_a_next;
  acs_pkg::word_t                    reg_d_next;
  logic                              halt_flag_next;

  acs_pkg::res_t                     rq [acs_pkg::QUEUE_DEPTH];
  logic [acs_pkg::QPTR_W-1:0]        wr_ptr;
  logic [acs_pkg::QPTR_W-1:0]        rd_ptr;
  logic [acs_pkg::QCNT_W-1:0]        count;
  acs_pkg::res_t                     res_new;
  logic                              exec;
  logic                              do_pop;

  acs_pkg::word_t                    xa, xb, ya, yb, y, sv, sa, z0, z1, z;
  acs_pkg::word_t                    pc_inc;
  logic                              wr;
  logic                              lt, eq, gt, take;

  assign dec_ready = (count != acs_pkg::QCNT_W'(acs_pkg::QUEUE_DEPTH));
  assign exec      = dec_valid && dec_ready;
  assign empty     = (count == '0);
  assign res       = rq[rd_ptr];
  assign do_pop    = pop && !empty;

  // ALU
  always_comb begin
    y  = dec.use_mem ? dec.mem_operand : reg_a;
    xa = dec.op[acs_pkg::OP_ZX] ? '0 : reg_d;
    xb = dec.op[acs_pkg::OP_NX] ? ~xa : xa;
    ya = dec.op[acs_pkg::OP_ZY] ? '0 : y;
    yb = dec.op[acs_pkg::OP_NY] ? ~ya : ya;
    sv = dec.op[acs_pkg::OP_F] ? xb : yb;
    sa = dec.op[acs_pkg::OP_F] ? yb : xb;
    if (dec.op[acs_pkg::OP_SH]) begin
      z0 = acs_pkg::shift_by(sv, sa);
    end else if (dec.op[acs_pkg::OP_F]) begin
      z0 = xb + yb;
    end else begin
      z0 = xb & yb;
    end
    z1 = dec.op[acs_pkg::OP_REV] ? acs_pkg::bit_reverse(z0) : z0;
    z  = dec.op[acs_pkg::OP_NO] ? ~z1 : z1;
  end

  // Next architectural state for the instruction at the queue head.
  always_comb begin
    pc_inc            = prog_counter + acs_pkg::PC_STEP;
    prog_counter_next = prog_counter;
    reg_a_next        = reg_a;
    reg_d_next        = reg_d;
    halt_flag_next    = halt_flag;
    wr                = 1'b0;
    lt                = z[acs_pkg::WORD_W-1];
    eq                = (z == '0);
    gt                = !lt && !eq;
    take              = (dec.jmp[acs_pkg::JMP_LT] && lt) || (dec.jmp[acs_pkg::JMP_EQ] && eq) ||
                        (dec.jmp[acs_pkg::JMP_GT] && gt);
    if (!halt_flag) begin
      prog_counter_next = pc_inc;
      if (dec.is_compute) begin
        if (dec.dst[acs_pkg::DST_D]) begin
          reg_d_next = z;
        end
        if (dec.dst[acs_pkg::DST_A]) begin
          reg_a_next = z;
        end
        wr = dec.dst[acs_pkg::DST_MEM];
        // The jump target is A after this instruction's own write.
        if (take) begin
          prog_counter_next = reg_a_next;
        end
      end else begin
        reg_a_next = dec.load_value;
      end
      if (prog_counter_next == acs_pkg::HALT_PC) begin
        halt_flag_next = 1'b1;
      end
    end

    res_new.next_pc        = prog_counter_next;
    res_new.a_value        = reg_a_next;
    res_new.d_value        = reg_d_next;
    res_new.mem_write      = wr;
    res_new.mem_write_addr = wr ? reg_a_next : '0;
    res_new.mem_write_data = wr ? z[acs_pkg::BYTE_W-1:0] : '0;
    res_new.halted         = halt_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_counter <= '0;
      reg_a        <= '0;
      reg_d        <= '0;
      halt_flag    <= 1'b0;
    end else if (cfg_valid) begin
      prog_counter <= cfg_data;
    end else if (exec) begin
      prog_counter <= prog_counter_next;
      reg_a        <= reg_a_next;
      reg_d        <= reg_d_next;
      halt_flag    <= halt_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      rq[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (exec) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (exec && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !exec) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/accumulator_cpu_step_top.sv -----
// Top level of the accumulator CPU step block: front end, back end and wiring.
// Depends on acs_pkg, acs_front and acs_back.
//
// Usage: each input beat (push while full is low) carries one instruction word
// and the byte at address A. It yields exactly one result beat, read from the
// result side like a queue: the oldest result is on the ports while empty is
// low and leaves at an edge with pop high.
// The front end decodes the beat into a two-entry queue; the back end executes
// one queued instruction per cycle while the result queue has room and writes
// a two-entry result queue. Throughput: one instruction per cycle while the
// receiver keeps popping, set by the execute stage with its ALU, shifter and
// branch compare. When the receiver stops popping, the result queue fills,
// execution stops, then the decode queue fills and full rises; nothing is
// lost. Reset (rst, synchronous) empties both queues and clears A, D, the
// program counter and the halt flag. A write on the start_address channel
// (always ready) loads the program counter at once; the user must see that it
// is made only while idle, which the block itself does not enforce.
module accumulator_cpu_step_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        instruction,
  input  logic [7:0]         operand_byte,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        next_pc,
  output logic signed [15:0] a_value,
  output logic signed [15:0] d_value,
  output logic               mem_write,
  output logic [15:0]        mem_write_addr,
  output logic [7:0]         mem_write_data,
  output logic               halted,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        start_address
);

  logic           dec_valid;
  logic           dec_ready;
  acs_pkg::dec_t  dec;
  acs_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  acs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .instruction  (instruction),
    .operand_byte (operand_byte),
    .dec_valid    (dec_valid),
    .dec          (dec),
    .dec_ready    (dec_ready)
  );

  acs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (start_address),
    .dec_valid (dec_valid),
    .dec       (dec),
    .dec_ready (dec_ready),
    .empty     (empty),
    .pop       (pop),
    .res       (res)
  );

  assign next_pc        = res.next_pc;
  assign a_value        = $signed(res.a_value);
  assign d_value        = $signed(res.d_value);
  assign mem_write      = res.mem_write;
  assign mem_write_addr = res.mem_write_addr;
  assign mem_write_data = res.mem_write_data;
  assign halted         = res.halted;

endmodule

// ----- tb/sv/tb_accumulator_cpu_step_top.sv -----
// Self-checking testbench for accumulator_cpu_step_top: directed and random instruction
// streams, several entry points, a forced long result stall and a final halt.
// Depends on acs_pkg and the block itself; everything else is generated here.
`timescale 1ns / 100ps

module tb_accumulator_cpu_step_top;

  typedef struct packed {
    acs_pkg::word_t pc;
    acs_pkg::word_t a;
    acs_pkg::word_t d;
    logic           halt;
  } cpu_state_t;

  typedef struct packed {
    cpu_state_t    st;
    acs_pkg::res_t res;
  } step_t;

  typedef struct packed {
    acs_pkg::word_t ins;
    logic [7:0]     mem_byte;
  } item_t;

  // ALU opcodes built from the flag bits.
  localparam logic [7:0] ALU_AND      = 8'h00;
  localparam logic [7:0] ALU_ADD      = 8'(1 << acs_pkg::OP_F);
  localparam logic [7:0] ALU_PASS_Y   = 8'((1 << acs_pkg::OP_ZX) | (1 << acs_pkg::OP_F));
  localparam logic [7:0] ALU_SHIFT_D  = 8'((1 << acs_pkg::OP_SH) | (1 << acs_pkg::OP_F));
  localparam logic [7:0] ALU_SHIFT_Y  = 8'(1 << acs_pkg::OP_SH);
  localparam logic [7:0] ALU_ZERO     = 8'((1 << acs_pkg::OP_ZX) | (1 << acs_pkg::OP_ZY));
  localparam logic [7:0] ALU_ALL_ONES = 8'((1 << acs_pkg::OP_ZX) | (1 << acs_pkg::OP_ZY) |
                                           (1 << acs_pkg::OP_NO));
  localparam logic [7:0] ALU_ADD_REV_INV = 8'((1 << acs_pkg::OP_F) | (1 << acs_pkg::OP_REV) |
                                              (1 << acs_pkg::OP_NO));
  localparam logic [7:0] ALU_NOT_X_AND_NOT_Y = 8'((1 << acs_pkg::OP_NX) | (1 << acs_pkg::OP_NY));

  localparam logic [2:0] NO_DEST = 3'b000;
  localparam logic [2:0] TO_MEM  = 3'(1 << acs_pkg::DST_MEM);
  localparam logic [2:0] TO_D    = 3'(1 << acs_pkg::DST_D);
  localparam logic [2:0] TO_A    = 3'(1 << acs_pkg::DST_A);
  localparam logic [2:0] NO_JUMP = 3'b000;
  localparam logic [2:0] ON_LT   = 3'(1 << acs_pkg::JMP_LT);
  localparam logic [2:0] ON_EQ   = 3'(1 << acs_pkg::JMP_EQ);
  localparam logic [2:0] ON_GT   = 3'(1 << acs_pkg::JMP_GT);
  localparam logic [2:0] ALWAYS  = ON_LT | ON_EQ | ON_GT;

  localparam int IDLE_PCT   = 8;
  localparam int HOLD_AFTER = 600;
  localparam int HOLD_LEN   = 80;

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [15:0]        instruction = '0;
  logic [7:0]         operand_byte = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [15:0]        next_pc;
  logic signed [15:0] a_value;
  logic signed [15:0] d_value;
  logic               mem_write;
  logic [15:0]        mem_write_addr;
  logic [7:0]         mem_write_data;
  logic               halted;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        start_address = '0;

  accumulator_cpu_step_top dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .instruction    (instruction),
    .operand_byte   (operand_byte),
    .empty          (empty),
    .pop            (pop),
    .next_pc        (next_pc),
    .a_value        (a_value),
    .d_value        (d_value),
    .mem_write      (mem_write),
    .mem_write_addr (mem_write_addr),
    .mem_write_data (mem_write_data),
    .halted         (halted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .start_address  (start_address)
  );

  item_t         instr_queue[$];
  acs_pkg::res_t results_due[$];
  cpu_state_t    core_state;   // advanced on every accepted input beat
  cpu_state_t    plan_state;   // advanced as items are generated, used to steer clear of halting
  bit            quiet = 1'b0;
  bit            halt_allowed = 1'b0;
  int            faults = 0;
  int            items_sent = 0;
  int            results_seen = 0;
  int            halted_seen = 0;
  int            cfg_writes = 0;
  int            stall_left = 0;
  bit            stall_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Timed out with %0d results still due", results_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Signed shift: a negative amount shifts right arithmetically by its magnitude.
  function automatic acs_pkg::word_t shift_signed(acs_pkg::word_t v, acs_pkg::word_t amt);
    int             n;
    int             k;
    acs_pkg::word_t r;
    if (amt[acs_pkg::WORD_W-1]) begin
      n = 65536 - int'(amt);
      if (n >= acs_pkg::WORD_W) begin
        r = {acs_pkg::WORD_W{v[acs_pkg::WORD_W-1]}};
      end else begin
        r = v >> n;
        for (k = acs_pkg::WORD_W - n; k < acs_pkg::WORD_W; k++) r[k] = v[acs_pkg::WORD_W-1];
      end
    end else begin
      n = int'(amt);
      r = (n >= acs_pkg::WORD_W) ? '0 : acs_pkg::word_t'(v << n);
    end
    return r;
  endfunction

  function automatic acs_pkg::word_t reverse_bits(acs_pkg::word_t v);
    acs_pkg::word_t r;
    int             k;
    for (k = 0; k < acs_pkg::WORD_W; k++) r[acs_pkg::WORD_W-1-k] = v[k];
    return r;
  endfunction

  function automatic acs_pkg::word_t alu_eval(logic [7:0] op, acs_pkg::word_t x,
                                              acs_pkg::word_t y);
    acs_pkg::word_t xs;
    acs_pkg::word_t ys;
    acs_pkg::word_t z;
    xs = op[acs_pkg::OP_ZX] ? '0 : x;
    if (op[acs_pkg::OP_NX]) xs = ~xs;
    ys = op[acs_pkg::OP_ZY] ? '0 : y;
    if (op[acs_pkg::OP_NY]) ys = ~ys;
    if (op[acs_pkg::OP_SH]) z = op[acs_pkg::OP_F] ? shift_signed(xs, ys) : shift_signed(ys, xs);
    else z = op[acs_pkg::OP_F] ? acs_pkg::word_t'(xs + ys) : (xs & ys);
    if (op[acs_pkg::OP_REV]) z = reverse_bits(z);
    if (op[acs_pkg::OP_NO]) z = ~z;
    return z;
  endfunction

  function automatic step_t cpu_step(cpu_state_t s, acs_pkg::word_t ins, logic [7:0] mb);
    step_t          o;
    acs_pkg::word_t y;
    acs_pkg::word_t z;
    logic [2:0]     dst;
    logic [2:0]     jmp;
    logic           wr;
    logic [7:0]     wdata;
    logic           neg;
    logic           zero;
    wr = 1'b0;
    wdata = '0;
    if (!s.halt) begin
      s.pc = s.pc + acs_pkg::PC_STEP;
      if (ins[acs_pkg::INS_COMPUTE]) begin
        dst = ins[acs_pkg::INS_DST_LO +: 3];
        jmp = ins[acs_pkg::INS_JMP_LO +: 3];
        y = ins[acs_pkg::INS_USE_MEM] ? {{8{mb[7]}}, mb} : s.a;
        z = alu_eval(ins[acs_pkg::INS_OP_LO +: 8], s.d, y);
        if (dst[acs_pkg::DST_D]) s.d = z;
        if (dst[acs_pkg::DST_A]) s.a = z;
        if (dst[acs_pkg::DST_MEM]) begin
          wr = 1'b1;
          wdata = z[7:0];
        end
        neg = z[acs_pkg::WORD_W-1];
        zero = (z == '0);
        // The jump target is A after this instruction has written it.
        if ((jmp[acs_pkg::JMP_LT] && neg) || (jmp[acs_pkg::JMP_EQ] && zero) ||
            (jmp[acs_pkg::JMP_GT] && !neg && !zero))
          s.pc = s.a;
      end else if (ins[acs_pkg::INS_LOAD_HI]) begin
        s.a = ins | 16'h0001;
      end else begin
        s.a = ins >> 1;
      end
      if (s.pc == acs_pkg::HALT_PC) s.halt = 1'b1;
    end
    o.st = s;
    o.res.next_pc = s.pc;
    o.res.a_value = s.a;
    o.res.d_value = s.d;
    o.res.mem_write = wr;
    o.res.mem_write_addr = wr ? s.a : '0;
    o.res.mem_write_data = wr ? wdata : '0;
    o.res.halted = s.halt;
    return o;
  endfunction

  function automatic acs_pkg::word_t compute_word(logic [7:0] op, logic [2:0] dst,
                                                  logic [2:0] jmp, logic use_mem);
    acs_pkg::word_t w;
    w = '0;
    w[acs_pkg::INS_COMPUTE] = 1'b1;
    w[acs_pkg::INS_USE_MEM] = use_mem;
    w[acs_pkg::INS_OP_LO +: 8] = op;
    w[acs_pkg::INS_DST_LO +: 3] = dst;
    w[acs_pkg::INS_JMP_LO +: 3] = jmp;
    return w;
  endfunction

  // Halting is permanent, so until the last phase any item that would halt is
  // swapped for one that clears A and jumps to address zero.
  task automatic queue_instr(acs_pkg::word_t ins, logic [7:0] mb);
    step_t nxt;
    item_t it;
    nxt = cpu_step(plan_state, ins, mb);
    if (!halt_allowed && nxt.st.halt) begin
      ins = compute_word(ALU_ZERO, TO_A, ALWAYS, 1'b0);
      nxt = cpu_step(plan_state, ins, mb);
    end
    plan_state = nxt.st;
    it.ins = ins;
    it.mem_byte = mb;
    instr_queue.push_back(it);
  endtask

  task automatic queue_random(int count);
    int             k;
    int             sel;
    acs_pkg::word_t ins;
    for (k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        ins = acs_pkg::word_t'($urandom_range(0, 65535));
      end else if (sel < 65) begin
        ins = acs_pkg::word_t'($urandom_range(0, 40) << 1);       // small positive A
      end else if (sel < 72) begin
        ins = 16'hFFE0 | acs_pkg::word_t'($urandom_range(0, 31)); // small negative A
      end else begin
        ins = compute_word(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                           3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
      queue_instr(ins, 8'($urandom_range(0, 255)));
    end
  endtask

  // Sender stays quiet until every result is back.
  task automatic drain_all();
    while (instr_queue.size() != 0 || results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_start(acs_pkg::word_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    start_address <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    core_state.pc = v;
    plan_state.pc = v;
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= 10)
        $display("Mismatch on %s in result %0d: expected %h, got %h",
                 name, results_seen, want, got);
    end
  endtask

  // Input side: offers the head of the queue and predicts each accepted beat.
  always @(posedge clk) begin
    step_t nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        nxt = cpu_step(core_state, instruction, operand_byte);
        core_state = nxt.st;
        results_due.push_back(nxt.res);
        items_sent++;
        instr_queue.delete(0);
      end
      // An offered beat that met a full block is held unchanged.
      if (!(push && full)) begin
        if (instr_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          push <= 1'b1;
          instruction <= instr_queue[0].ins;
          operand_byte <= instr_queue[0].mem_byte;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each popped beat and stalls at random and once for long.
  always @(posedge clk) begin
    acs_pkg::res_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          faults++;
          if (faults <= 10) $display("Result beat with nothing due, pc %h", next_pc);
        end else begin
          want = results_due.pop_front();
          check_field("next_pc", want.next_pc, next_pc);
          check_field("a_value", want.a_value, a_value);
          check_field("d_value", want.d_value, d_value);
          check_field("mem_write", 16'(want.mem_write), 16'(mem_write));
          check_field("mem_write_addr", want.mem_write_addr, mem_write_addr);
          check_field("mem_write_data", 16'(want.mem_write_data), 16'(mem_write_data));
          check_field("halted", 16'(want.halted), 16'(halted));
        end
        if (halted === 1'b1) halted_seen++;
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!stall_done && results_seen >= HOLD_AFTER) begin
        stall_left = HOLD_LEN;
        stall_done = 1'b1;
      end
      pop <= (stall_left == 0) && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    core_state = '0;
    plan_state = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part from the reset entry point.
    queue_instr(16'h0000, 8'h00);                                   // load A = 0
    queue_instr(16'hFFFE, 8'hFF);                                   // load A = 0xFFFF
    queue_instr(compute_word(ALU_PASS_Y, TO_D, NO_JUMP, 1'b1), 8'h80);
    queue_instr(compute_word(ALU_PASS_Y, TO_D, NO_JUMP, 1'b1), 8'h7F);
    queue_instr(16'h7FFE, 8'h00);                                   // load A = 0x3FFF
    queue_instr(compute_word(ALU_ADD, TO_D | TO_MEM, NO_JUMP, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_AND, TO_A, NO_JUMP, 1'b0), 8'h00);
    queue_instr(16'h0008, 8'h00);                                   // load A = 4
    queue_instr(compute_word(ALU_SHIFT_D, TO_D, NO_JUMP, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_PASS_Y, TO_D, NO_JUMP, 1'b1), 8'h81);
    queue_instr(16'h0028, 8'h00);                                   // load A = 20
    queue_instr(compute_word(ALU_SHIFT_D, TO_D | TO_MEM, NO_JUMP, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_PASS_Y, TO_D, NO_JUMP, 1'b1), 8'h80);
    queue_instr(16'hFFF0, 8'h00);                                   // load A = -15
    queue_instr(compute_word(ALU_SHIFT_D, TO_D, NO_JUMP, 1'b0), 8'h00);
    queue_instr(16'h7FFE, 8'h00);
    queue_instr(compute_word(ALU_PASS_Y, TO_D, NO_JUMP, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_SHIFT_D, TO_MEM, NO_JUMP, 1'b1), 8'hF0);
    queue_instr(compute_word(ALU_SHIFT_D, TO_D, NO_JUMP, 1'b1), 8'hFC);
    queue_instr(compute_word(ALU_PASS_Y, TO_D, NO_JUMP, 1'b1), 8'h03);
    queue_instr(compute_word(ALU_SHIFT_Y, TO_A, NO_JUMP, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_ADD_REV_INV, TO_D | TO_MEM, NO_JUMP, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_NOT_X_AND_NOT_Y, TO_D, NO_JUMP, 1'b0), 8'h00);
    queue_instr(16'h0200, 8'h00);                                   // load A = 0x0100
    queue_instr(compute_word(ALU_ZERO, NO_DEST, ON_LT | ON_GT, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_ZERO, NO_DEST, ON_EQ, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_ALL_ONES, NO_DEST, ON_LT, 1'b0), 8'h00);
    queue_instr(compute_word(ALU_PASS_Y, TO_D, ON_GT, 1'b1), 8'h05);
    queue_random(150);
    drain_all();

    write_start(16'hFFFF);
    queue_random(170);
    drain_all();

    // A stretch with no idling on either side.
    quiet = 1'b1;
    write_start(16'hFFFE);
    queue_random(170);
    drain_all();
    quiet = 1'b0;

    write_start(acs_pkg::word_t'($urandom_range(0, 65535)));
    queue_random(170);
    drain_all();

    write_start(16'h0000);
    queue_random(150);
    drain_all();

    // Jump to 0xFFFF halts the core; the rest of the beats must be ignored.
    halt_allowed = 1'b1;
    write_start(16'h0100);
    queue_instr(16'hFFFE, 8'h00);
    queue_instr(compute_word(ALU_ZERO, NO_DEST, ON_EQ, 1'b0), 8'h00);
    queue_random(30);
    while (instr_queue.size() != 0 || results_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (results_due.size() != 0) begin
      faults += results_due.size();
      $display("%0d results never arrived", results_due.size());
    end
    $display("Sent %0d instructions over %0d entry-point writes; checked %0d results,",
             items_sent, cfg_writes, results_seen);
    $display("%0d of them after halt, with %0d faults", halted_seen, faults);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/acs_pkg.sv
hdl/acs_front.sv
hdl/acs_back.sv
hdl/accumulator_cpu_step_top.sv
tb/sv/tb_accumulator_cpu_step_top.sv
